// ----- src/jel_pkg.sv -----
// jel_pkg: shared types and constants for the jpeg exif header locator
// holds the parse phase enum, status codes, marker codes and the result struct
// no dependencies
package jel_pkg;

  typedef enum logic [3:0] {
    PH_SOI0       = 4'd0,
    PH_SOI1       = 4'd1,
    PH_MARK       = 4'd2,
    PH_CODE       = 4'd3,
    PH_LEN        = 4'd4,
    PH_SKIP       = 4'd5,
    PH_ID         = 4'd6,
    PH_TIFF       = 4'd7,
    PH_HOLD_UNSUP = 4'd8,
    PH_HOLD_NF    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_UNSUP    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_SOS    = 8'hDA;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_APP1   = 8'hE1;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_RST7   = 8'hD7;
  localparam logic [7:0] MK_STUFF  = 8'h00;
  localparam logic [7:0] MK_TEM    = 8'h01;
  localparam logic [7:0] BO_BIG    = 8'h4D;
  localparam logic [7:0] BO_LITTLE = 8'h49;
  localparam logic [15:0] TIFF_MAGIC = 16'd42;

  typedef struct packed {
    logic        valid;
    status_t     status;
    logic        msb_first;
    logic [31:0] ifd_offset;
    logic [15:0] tiff_length;
  } jel_result_t;

  // "Exif\0\0" identifier bytes
  function automatic logic [7:0] exif_id_byte(input logic [2:0] idx);
    logic [7:0] r;
    case (idx)
      3'd0:    r = 8'h45;
      3'd1:    r = 8'h78;
      3'd2:    r = 8'h69;
      3'd3:    r = 8'h66;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

// ----- src/jel_parser.sv -----
// jel_parser: marker walk and exif/tiff header check, one file byte per step
// holds all parse state; gives at most one result per file
// depends on jel_pkg
module jel_parser import jel_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output jel_result_t result
);

  phase_t      phase, phase_next;
  logic [3:0]  idx, idx_next;
  logic [15:0] skip, skip_next;
  logic [15:0] seglen, seglen_next;
  logic [7:0]  marker, marker_next;
  logic        big, big_next;
  logic [31:0] word, word_next;
  logic [2:0]  seen, seen_next;
  logic        given, given_next;

  logic        emit;
  status_t     emit_status;

  logic        decided;
  status_t     dec_status;
  logic [15:0] len_new;
  logic [15:0] skip_dec;
  logic [31:0] word_acc;
  logic        seen4;

  always_comb begin
    phase_next  = phase;
    idx_next    = idx;
    skip_next   = skip;
    seglen_next = seglen;
    marker_next = marker;
    big_next    = big;
    word_next   = word;
    seen_next   = seen;
    given_next  = given;
    decided     = 1'b0;
    dec_status  = ST_NOTFOUND;
    emit        = 1'b0;
    emit_status = ST_NOTFOUND;
    len_new     = {seglen[7:0], data_byte};
    skip_dec    = (skip != 16'd0) ? skip - 16'd1 : skip;
    word_acc    = word;
    seen4       = 1'b0;

    if (!given) begin
      seen_next = (seen < 3'd4) ? seen + 3'd1 : seen;
      seen4     = (seen_next >= 3'd4);
      case (phase)
        PH_SOI0: begin
          if (data_byte == MK_PREFIX) phase_next = PH_SOI1;
          else begin decided = 1'b1; dec_status = ST_UNSUP; end
        end
        PH_SOI1: begin
          if (data_byte == MK_SOI) phase_next = PH_MARK;
          else begin decided = 1'b1; dec_status = ST_UNSUP; end
        end
        PH_MARK: begin
          if (data_byte == MK_PREFIX) phase_next = PH_CODE;
          else decided = 1'b1;
        end
        PH_CODE: begin
          marker_next = data_byte;
          if (data_byte == MK_SOS || data_byte == MK_EOI) begin
            decided = 1'b1;
          end else if (data_byte == MK_STUFF || data_byte == MK_TEM ||
                       (data_byte >= MK_RST0 && data_byte <= MK_RST7)) begin
            phase_next = PH_MARK;
          end else begin
            phase_next  = PH_LEN;
            idx_next    = 4'd0;
            seglen_next = 16'd0;
          end
        end
        PH_LEN: begin
          seglen_next = len_new;
          if (idx == 4'd0) begin
            idx_next = 4'd1;
          end else if (len_new < 16'd2) begin
            decided = 1'b1;
          end else begin
            skip_next = len_new - 16'd2;
            idx_next  = 4'd0;
            if (marker == MK_APP1 && len_new >= 16'd8) phase_next = PH_ID;
            else phase_next = (len_new == 16'd2) ? PH_MARK : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_next  = skip_dec;
          phase_next = (skip_dec == 16'd0) ? PH_MARK : PH_SKIP;
        end
        PH_ID: begin
          skip_next = skip_dec;
          if (idx >= 4'd6 || data_byte != exif_id_byte(idx[2:0])) begin
            phase_next = (skip_dec == 16'd0) ? PH_MARK : PH_SKIP;
          end else if (idx < 4'd5) begin
            idx_next = idx + 4'd1;
          end else if ((seglen - 16'd8) < 16'd8) begin
            decided = 1'b1;
          end else begin
            phase_next = PH_TIFF;
            idx_next   = 4'd0;
          end
        end
        PH_TIFF: begin
          if (idx == 4'd0) begin
            word_next = {24'd0, data_byte};
            idx_next  = 4'd1;
          end else if (idx == 4'd1) begin
            if (word == {24'd0, data_byte} &&
                (data_byte == BO_BIG || data_byte == BO_LITTLE)) begin
              big_next  = (data_byte == BO_BIG);
              word_next = 32'd0;
              idx_next  = 4'd2;
            end else begin
              decided = 1'b1;
            end
          end else if (idx <= 4'd7) begin
            // little-endian places the byte by its position in the field
            if (big) word_acc = {word[23:0], data_byte};
            else word_acc = word | ({24'd0, data_byte} << {idx[2] & idx[1], idx[0], 3'b000});
            if (idx <= 4'd3) begin
              word_next = word_acc;
              idx_next  = idx + 4'd1;
              if (idx == 4'd3) begin
                if (word_acc[15:0] != TIFF_MAGIC) decided = 1'b1;
                else word_next = 32'd0;
              end
            end else begin
              word_next = word_acc;
              if (idx == 4'd7) begin
                decided    = 1'b1;
                dec_status = ST_OK;
              end else begin
                idx_next = idx + 4'd1;
              end
            end
          end else begin
            decided = 1'b1;
          end
        end
        default: ;
      endcase

      if (decided) begin
        if (seen4) begin
          emit        = 1'b1;
          emit_status = dec_status;
        end else begin
          phase_next = (dec_status == ST_UNSUP) ? PH_HOLD_UNSUP : PH_HOLD_NF;
        end
      end else if (phase_next == PH_HOLD_UNSUP && seen4) begin
        emit        = 1'b1;
        emit_status = ST_UNSUP;
      end else if (phase_next == PH_HOLD_NF && seen4) begin
        emit        = 1'b1;
        emit_status = ST_NOTFOUND;
      end

      if (!emit && last_byte) begin
        emit = 1'b1;
        if (!seen4) emit_status = ST_INVALID;
        else if (phase_next == PH_HOLD_UNSUP) emit_status = ST_UNSUP;
        else emit_status = ST_NOTFOUND;
      end

      if (emit) given_next = 1'b1;
    end

    // end of file brings everything back to the start
    if (last_byte) begin
      phase_next  = PH_SOI0;
      idx_next    = 4'd0;
      skip_next   = 16'd0;
      seglen_next = 16'd0;
      marker_next = 8'd0;
      big_next    = 1'b0;
      word_next   = 32'd0;
      seen_next   = 3'd0;
      given_next  = 1'b0;
    end
  end

  always_comb begin
    result = '0;
    result.valid  = emit;
    result.status = emit_status;
    if (emit_status == ST_OK) begin
      result.msb_first   = big;
      result.ifd_offset  = word_acc;
      result.tiff_length = seglen - 16'd8;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SOI0;
      idx    <= 4'd0;
      skip   <= 16'd0;
      seglen <= 16'd0;
      marker <= 8'd0;
      big    <= 1'b0;
      word   <= 32'd0;
      seen   <= 3'd0;
      given  <= 1'b0;
    end else if (step) begin
      phase  <= phase_next;
      idx    <= idx_next;
      skip   <= skip_next;
      seglen <= seglen_next;
      marker <= marker_next;
      big    <= big_next;
      word   <= word_next;
      seen   <= seen_next;
      given  <= given_next;
    end
  end

endmodule

// ----- src/jpeg_exif_header_locator.sv -----
// jpeg_exif_header_locator: top level, input register, parser and result register
// depends on jel_pkg and jel_parser
//
// Takes one file byte per cycle while in_stall is low and gives one result item per
// file (status, byte order, IFD0 offset, TIFF length). A byte goes into an input
// register and is parsed from there when the parser advances; its result, if any,
// is registered into the output register on that advance. Throughput is one byte
// per cycle while the output side does not stall; a held result in the output
// register stops parsing until it is taken, and in_stall then rises once the input
// register is full.
module jpeg_exif_header_locator import jel_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        msb_first,
  output logic [31:0] ifd_offset,
  output logic [15:0] tiff_length
);

  logic        q_valid;
  logic [7:0]  q_byte;
  logic        q_last;
  logic        advance;
  logic        in_take;
  jel_result_t res;
  jel_result_t out_q;

  assign advance  = q_valid && (!out_valid || !out_stall);
  assign in_stall = q_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  jel_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .data_byte (q_byte),
    .last_byte (q_last),
    .result    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_take) begin
      q_valid <= 1'b1;
    end else if (advance) begin
      q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      q_byte <= data_byte;
      q_last <= last_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      out_q <= res;
    end
  end

  assign status      = out_q.status;
  assign msb_first   = out_q.msb_first;
  assign ifd_offset  = out_q.ifd_offset;
  assign tiff_length = out_q.tiff_length;

endmodule
